@@ rtl/differential_drive_odometry_top_assert.svh @@
// ----------------------------------------------------------------------------
// Differential drive odometry assertion macros
// Concurrent property wrappers clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_TOP_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_TOP_ASSERT_SVH

// same-cycle implication
`define DDO_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DDO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ddo_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared widths, constants, types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int POS_FRAC_BITS = 8;
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STEPS  = 16;

  localparam int CNT_W   = 32;
  localparam int DELTA_W = 16;
  localparam int NUM_W   = 16;
  localparam int DEN_W   = 16;
  localparam int BASE_W  = 12;
  localparam int POS_W   = 32;
  localparam int HEAD_W  = 16;

  localparam int PRD_W  = NUM_W + DELTA_W - 1;
  localparam int MAG_W  = PRD_W + POS_FRAC_BITS;
  localparam int TRAV_W = MAG_W + 1;
  localparam int HMAG_W = TRAV_W + 14;
  localparam int HQ_W   = HMAG_W + 1;
  localparam int CV_W   = 34;
  localparam int CS_W   = 18;
  localparam int PROD_W = TRAV_W + CS_W;
  localparam int STEP_W = 5;

  localparam int HSHIFT = POS_FRAC_BITS + 16 - ANGLE_BITS;
  localparam int HSR    = (HSHIFT >= 0) ? HSHIFT : 0;
  localparam int HSL    = (HSHIFT < 0) ? -HSHIFT : 0;
  localparam int OSR    = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int OSL    = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd2;

  localparam logic [NUM_W-1:0]  NUM_RESET  = 16'd1;
  localparam logic [DEN_W-1:0]  DEN_RESET  = 16'd1;
  localparam logic [BASE_W-1:0] BASE_RESET = 12'd140;

  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
  localparam logic [13:0]        INV_TWO_PI_Q16  = 14'd10430;
  localparam logic signed [31:0] QUARTER_TURN    = 32'sd1073741824;

  typedef struct packed {
    logic signed [DELTA_W-1:0] right;
    logic signed [DELTA_W-1:0] left;
  } ddo_delta_t;

  typedef struct packed {
    logic                   done;
    logic signed [CS_W-1:0] cos_q15;
    logic signed [CS_W-1:0] sin_q15;
  } ddo_trig_t;

  function automatic logic [31:0] atan_at(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/ddo_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo channel interfaces
// Valid/ready channels for encoder counts, pose results and register writes.
// ----------------------------------------------------------------------------
interface ddo_in_if import ddo_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [CNT_W-1:0] right_count;
  logic signed [CNT_W-1:0] left_count;
  modport source (output valid, right_count, left_count, input ready);
  modport sink (input valid, right_count, left_count, output ready);
endinterface

interface ddo_out_if import ddo_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [HEAD_W-1:0] heading;
  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface ddo_cfg_if import ddo_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/ddo_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_front
// Takes encoder count beats, forms saturated tick deltas, feeds the queue.
// ----------------------------------------------------------------------------
module ddo_front import ddo_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ddo_in_if.sink     in_if,
  input  logic       q_full,
  output logic       push,
  output ddo_delta_t push_data
);

  logic [CNT_W-1:0] last_right_r, last_right_nxt;
  logic [CNT_W-1:0] last_left_r, last_left_nxt;

  function automatic logic signed [DELTA_W-1:0] sat_delta(input logic [CNT_W-1:0] d);
    logic signed [CNT_W-1:0] s;
    s = signed'(d);
    if (s > 32'sd32767) return 16'sd32767;
    if (s < -32'sd32767) return -16'sd32767;
    return s[DELTA_W-1:0];
  endfunction

  assign in_if.ready = !q_full;
  assign push = in_if.valid && in_if.ready;

  always_comb begin
    push_data.right = sat_delta(in_if.right_count - last_right_r);
    push_data.left  = sat_delta(in_if.left_count - last_left_r);
    last_right_nxt  = push ? in_if.right_count : last_right_r;
    last_left_nxt   = push ? in_if.left_count : last_left_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_right_r <= '0;
      last_left_r  <= '0;
    end else begin
      last_right_r <= last_right_nxt;
      last_left_r  <= last_left_nxt;
    end
  end

endmodule

@@ rtl/ddo_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_queue
// Two-entry queue of tick deltas between front and back.
// ----------------------------------------------------------------------------
module ddo_queue import ddo_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  ddo_delta_t push_data,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output ddo_delta_t head
);

  ddo_delta_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [Q_PTR_W:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (Q_PTR_W + 1)'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (Q_PTR_W + 1)'(push) - (Q_PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/ddo_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddo_div import ddo_pkg::*; #(
  parameter int NW = 39,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW+1:0] trial;

  assign busy     = busy_r;
  assign quotient = quo_r;

  always_comb begin
    trial    = {1'b0, rem_r, quo_r[NW-1]} - {2'b00, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DW+1]) begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DW-2:0], quo_r[NW-1]};
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

@@ rtl/ddo_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, Q15 cosine and sine.
// ----------------------------------------------------------------------------
module ddo_cordic import ddo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [ANGLE_BITS-1:0] heading,
  output ddo_trig_t             trig
);

  logic signed [CV_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic                   busy_r, busy_nxt, done_r, done_nxt, flip_r, flip_nxt;
  logic [31:0]            ang;
  logic                   flip0;
  logic signed [CV_W-1:0] xs, ys, at, xf, yf, xr, yr;

  always_comb begin
    ang   = 32'(heading) << (32 - ANGLE_BITS);
    flip0 = (signed'(ang) > QUARTER_TURN) || (signed'(ang) < -QUARTER_TURN);
    xs    = x_r >>> step_r;
    ys    = y_r >>> step_r;
    at    = CV_W'(signed'({1'b0, atan_at(step_r)}));
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    flip_nxt = flip_r;
    if (start) begin
      x_nxt    = CV_W'(CORDIC_GAIN_Q30);
      y_nxt    = '0;
      z_nxt    = CV_W'(signed'(flip0 ? (ang ^ 32'h8000_0000) : ang));
      flip_nxt = flip0;
      step_nxt = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (!z_r[CV_W-1]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
    xf = flip_r ? -x_r : x_r;
    yf = flip_r ? -y_r : y_r;
    xr = (xf + CV_W'(16384)) >>> 15;
    yr = (yf + CV_W'(16384)) >>> 15;
    trig.done    = done_r;
    trig.cos_q15 = xr[CS_W-1:0];
    trig.sin_q15 = yr[CS_W-1:0];
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

@@ rtl/ddo_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_back
// Sequencer for wheel travel, heading step and pose update; output register.
// ----------------------------------------------------------------------------
module ddo_back import ddo_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  ddo_delta_t        q_data,
  output logic              q_pop,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [BASE_W-1:0] base,
  ddo_out_if.source         out_if
);

  `include "differential_drive_odometry_top_assert.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIVW = 3'd2;
  localparam logic [2:0] ST_HMUL = 3'd3;
  localparam logic [2:0] ST_DIVH = 3'd4;
  localparam logic [2:0] ST_POSX = 3'd5;
  localparam logic [2:0] ST_POSY = 3'd6;
  localparam logic [2:0] ST_UPD  = 3'd7;

  logic [2:0]                state_r, state_nxt;
  ddo_delta_t                d_r, d_nxt;
  logic signed [TRAV_W-1:0]  dr_r, dr_nxt, dl_r, dl_nxt, dc_r, dc_nxt;
  logic                      hsign_r, hsign_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic [POS_W-1:0]          x_r, x_nxt, y_r, y_nxt;
  logic [ANGLE_BITS-1:0]     head_r, head_nxt;
  logic                      ov_r, ov_nxt;
  logic [POS_W-1:0]          ox_r, ox_nxt, oy_r, oy_nxt;
  logic [HEAD_W-1:0]         oh_r, oh_nxt;

  logic                      wstart, hstart, cstart, busy_rt, busy_lt, hbusy;
  logic [MAG_W-1:0]          mag_rt, mag_lt, q_rt, q_lt;
  logic [HMAG_W-1:0]         hmag, hq;
  logic [DEN_W-1:0]          den_eff;
  logic [BASE_W-1:0]         base_eff;
  ddo_trig_t                 trig;
  logic [DELTA_W-2:0]        abs_rt, abs_lt;
  logic signed [TRAV_W-1:0]  qs_rt, qs_lt;
  logic signed [TRAV_W:0]    tsum, tdiff;
  logic [TRAV_W-1:0]         adiff;
  logic signed [HQ_W-1:0]    hqs, dth;
  logic signed [31:0]        hext, hout;
  logic                      slot_free;

  ddo_cordic u_cordic (
    .clk, .rst_n, .start(cstart), .heading(head_r), .trig
  );

  ddo_div #(.NW(MAG_W), .DW(DEN_W)) u_div_rt (
    .clk, .rst_n, .start(wstart), .dividend(mag_rt), .divisor(den_eff),
    .busy(busy_rt), .quotient(q_rt)
  );

  ddo_div #(.NW(MAG_W), .DW(DEN_W)) u_div_lt (
    .clk, .rst_n, .start(wstart), .dividend(mag_lt), .divisor(den_eff),
    .busy(busy_lt), .quotient(q_lt)
  );

  ddo_div #(.NW(HMAG_W), .DW(BASE_W)) u_div_hd (
    .clk, .rst_n, .start(hstart), .dividend(hmag), .divisor(base_eff),
    .busy(hbusy), .quotient(hq)
  );

  assign out_if.valid   = ov_r;
  assign out_if.pos_x   = ox_r;
  assign out_if.pos_y   = oy_r;
  assign out_if.heading = oh_r;

  always_comb begin
    den_eff  = (den == '0) ? DEN_W'(1) : den;
    base_eff = (base == '0) ? BASE_W'(1) : base;
    abs_rt   = d_r.right[DELTA_W-1] ? (DELTA_W - 1)'(-d_r.right) : d_r.right[DELTA_W-2:0];
    abs_lt   = d_r.left[DELTA_W-1] ? (DELTA_W - 1)'(-d_r.left) : d_r.left[DELTA_W-2:0];
    mag_rt   = MAG_W'(PRD_W'(num) * PRD_W'(abs_rt)) << POS_FRAC_BITS;
    mag_lt   = MAG_W'(PRD_W'(num) * PRD_W'(abs_lt)) << POS_FRAC_BITS;
    qs_rt    = signed'({1'b0, q_rt});
    qs_lt    = signed'({1'b0, q_lt});
    tsum     = TRAV_W'(0) + (TRAV_W + 1)'(dr_r) + (TRAV_W + 1)'(dl_r);
    tdiff    = (TRAV_W + 1)'(dr_r) - (TRAV_W + 1)'(dl_r);
    adiff    = tdiff[TRAV_W] ? TRAV_W'(-tdiff) : tdiff[TRAV_W-1:0];
    hmag     = HMAG_W'(adiff) * HMAG_W'(INV_TWO_PI_Q16);
    hqs      = signed'({1'b0, hq});
    dth      = ((hsign_r ? -hqs : hqs) >>> HSR) << HSL;
    slot_free = !ov_r || out_if.ready;

    wstart = (state_r == ST_MUL);
    cstart = (state_r == ST_MUL);
    hstart = (state_r == ST_HMUL);
    q_pop  = 1'b0;

    state_nxt = state_r;
    d_nxt     = d_r;
    dr_nxt    = dr_r;
    dl_nxt    = dl_r;
    dc_nxt    = dc_r;
    hsign_nxt = hsign_r;
    prod_nxt  = prod_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    head_nxt  = head_r;
    ov_nxt    = ov_r && !out_if.ready;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    oh_nxt    = oh_r;
    hext      = 32'(signed'(head_r + dth[ANGLE_BITS-1:0]));
    hout      = (hext >>> OSR) << OSL;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          d_nxt     = q_data;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_DIVW;
      ST_DIVW: begin
        if (!busy_rt && !busy_lt && trig.done) begin
          dr_nxt    = d_r.right[DELTA_W-1] ? -qs_rt : qs_rt;
          dl_nxt    = d_r.left[DELTA_W-1] ? -qs_lt : qs_lt;
          state_nxt = ST_HMUL;
        end
      end
      ST_HMUL: begin
        hsign_nxt = tdiff[TRAV_W];
        dc_nxt    = TRAV_W'((tsum + (TRAV_W + 1)'(tsum[TRAV_W])) >>> 1);
        state_nxt = ST_DIVH;
      end
      ST_DIVH: begin
        if (!hbusy) begin
          prod_nxt  = dc_r * trig.cos_q15;
          state_nxt = ST_POSX;
        end
      end
      ST_POSX: begin
        x_nxt     = x_r + prod_r[15 +: POS_W];
        prod_nxt  = dc_r * trig.sin_q15;
        state_nxt = ST_POSY;
      end
      ST_POSY: begin
        y_nxt     = y_r + prod_r[15 +: POS_W];
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (slot_free) begin
          head_nxt  = head_r + dth[ANGLE_BITS-1:0];
          ov_nxt    = 1'b1;
          ox_nxt    = x_r;
          oy_nxt    = y_r;
          oh_nxt    = hout[HEAD_W-1:0];
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    d_r     <= d_nxt;
    dr_r    <= dr_nxt;
    dl_r    <= dl_nxt;
    dc_r    <= dc_nxt;
    hsign_r <= hsign_nxt;
    prod_r  <= prod_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    oh_r    <= oh_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      x_r     <= '0;
      y_r     <= '0;
      head_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      head_r  <= head_nxt;
      ov_r    <= ov_nxt;
    end
  end

  `DDO_ASSERT_NEXT(a_pop_starts, q_pop, state_r == ST_MUL, "pop did not start an item")
  `DDO_ASSERT_IMP(a_idle_quiet, state_r == ST_IDLE, !busy_rt && !busy_lt && !hbusy,
                  "divider busy while idle")
  `DDO_ASSERT_IMP(a_out_from_upd, $rose(ov_r), $past(state_r) == ST_UPD,
                  "result raised outside update step")
  `DDO_ASSERT_IMP(a_x_step, !$stable(x_r), $past(state_r) == ST_POSX,
                  "x moved outside its step")

endmodule

@@ rtl/differential_drive_odometry_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_top
// Wheel odometry: encoder counts in, dead-reckoned pose out.
// ----------------------------------------------------------------------------
// in_if carries absolute right/left encoder counts; each beat yields exactly
// one out_if beat with pos_x, pos_y (1/256 mm) and heading (65536 per turn).
// cfg_if writes tick numerator (0), tick denominator (1) and wheel base (2);
// it is always ready, and writes belong in idle time between items.
// The front takes a beat whenever its two-entry queue has room; the back
// runs one item at a time: it pops and starts, runs the two wheel travel
// dividers (CORDIC in their shadow), sets up, runs the heading divider and
// updates the pose, the dividers giving one quotient bit per cycle each.
// A result sits in the output register until taken; while it waits the back
// finishes the next item and holds, and the front keeps filling the queue.
// Synchronous reset clears pose, previous counts and the queue, and loads
// the registers with numerator 1, denominator 1 and base 140 mm.
// ----------------------------------------------------------------------------
module differential_drive_odometry_top import ddo_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ddo_in_if.sink    in_if,
  ddo_out_if.source out_if,
  ddo_cfg_if.sink   cfg_if
);

  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  logic              push, pop, q_full, q_valid;
  ddo_delta_t        push_data, q_head;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    base_nxt = base_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_NUM:  num_nxt  = cfg_if.data;
        CFG_DEN:  den_nxt  = cfg_if.data;
        CFG_BASE: base_nxt = cfg_if.data[BASE_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r  <= NUM_RESET;
      den_r  <= DEN_RESET;
      base_r <= BASE_RESET;
    end else begin
      num_r  <= num_nxt;
      den_r  <= den_nxt;
      base_r <= base_nxt;
    end
  end

  ddo_front u_front (
    .clk, .rst_n, .in_if, .q_full, .push, .push_data
  );

  ddo_queue u_queue (
    .clk, .rst_n, .push, .push_data, .pop, .full(q_full), .not_empty(q_valid),
    .head(q_head)
  );

  ddo_back u_back (
    .clk, .rst_n, .q_valid, .q_data(q_head), .q_pop(pop), .num(num_r),
    .den(den_r), .base(base_r), .out_if
  );

endmodule
